// File: rtl/fat12_cluster_chain_engine_defines.svh
// Assertion macros used by the FAT12 cluster chain engine RTL.
`ifndef FAT12_CLUSTER_CHAIN_ENGINE_DEFINES_SVH
`define FAT12_CLUSTER_CHAIN_ENGINE_DEFINES_SVH

// Implication checked in the same cycle, sampled on clk_i, off during reset.
`define FAT12CCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, sampled on clk_i, off during reset.
`define FAT12CCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fat12cce_pkg.sv
// Package with the types, codes and constants of the FAT12 cluster chain engine.
`default_nettype none

package fat12cce_pkg;

  localparam int NumClustersDef = 2880;

  localparam logic [11:0] LinkEoc    = 12'hFFF;
  localparam logic [11:0] LinkEocMin = 12'hFF8;
  localparam logic [11:0] LinkFree   = 12'h000;

  localparam logic [2:0] FuncLoad   = 3'd0;
  localparam logic [2:0] FuncRead   = 3'd1;
  localparam logic [2:0] FuncExtend = 3'd2;
  localparam logic [2:0] FuncClose  = 3'd3;
  localparam logic [2:0] FuncFind   = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] cluster;
    logic [23:0] packed_in;
  } req_t;

  typedef struct packed {
    logic [11:0] next_cluster;
    logic [23:0] packed_out;
    logic [12:0] pair_offset;
    logic        write_back;
    logic        status;
  } res_t;

  // Byte offset of a pair: (index / 2) * 3, done as a shift and an add.
  function automatic logic [12:0] pair_offset(input logic [11:0] cluster);
    logic [12:0] half;
    half = {2'b00, cluster[11:1]};
    return half + {half[11:0], 1'b0};
  endfunction

  // FAT12 packing puts the upper entry in bits 23:12 and the lower in 11:0.
  function automatic logic [23:0] pack_pair(input logic [11:0] lo, input logic [11:0] hi);
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

// File: rtl/fat12cce_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fat12cce_ram #(
  parameter int Width = 12,
  parameter int Depth = fat12cce_pkg::NumClustersDef,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [AddrW-1:0]         waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [AddrW-1:0]         raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fat12_cluster_chain_engine.sv
// Each beat passes S_DISP, where rejects end; load then ends in S_LOADHI, read in S_EVAL, find in
// S_SCAN; a close or extend that writes ends in S_PACK. A scan reads at most NUM_CLUSTERS entries.
// The free-cluster scan reads one link RAM entry per cycle through its single read port,
// so a new beat is taken only when busy is low, at the earliest on the strobe cycle.
// res_o is valid with the done_o strobe and held until the next beat; the receiver cannot stall it.
// Reset clears the sequencer only; the link table is undefined until loaded.
`default_nettype none

module fat12_cluster_chain_engine #(
  parameter int NUM_CLUSTERS = fat12cce_pkg::NumClustersDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire fat12cce_pkg::req_t  req_i,
  output logic                     done_o,
  output fat12cce_pkg::res_t       res_o
);

`include "fat12_cluster_chain_engine_defines.svh"

  localparam int AddrW = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam logic [12:0] NumCl = 13'(NUM_CLUSTERS);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(NUM_CLUSTERS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_LOADHI = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_PACK   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic                  done_q, done_d;
  fat12cce_pkg::req_t    req_q;
  fat12cce_pkg::res_t    res_q, res_d;
  logic [AddrW-1:0]      sidx_q, sidx_d;
  logic [11:0]           own_q, own_d;

  logic                  we;
  logic [AddrW-1:0]      waddr;
  logic [11:0]           wdata;
  logic [AddrW-1:0]      raddr;
  logic [11:0]           rdata;

  logic [11:0]           cl;
  logic [11:0]           partner;
  logic                  lower_ok, hi_ok, cl_ok, partner_ok;
  logic [11:0]           partner_val;
  logic [11:0]           free_idx;

  assign cl         = req_q.cluster;
  assign partner    = {cl[11:1], ~cl[0]};
  assign lower_ok   = {1'b0, cl[11:1], 1'b0} < NumCl;
  assign hi_ok      = {1'b0, cl[11:1], 1'b1} < NumCl;
  assign cl_ok      = (cl[11:1] != 11'd0) && ({1'b0, cl} < NumCl);
  assign partner_ok = {1'b0, partner} < NumCl;
  assign partner_val = partner_ok ? rdata : fat12cce_pkg::LinkFree;
  assign free_idx   = (rdata == fat12cce_pkg::LinkFree) ? 12'(sidx_q) : fat12cce_pkg::LinkEoc;

  fat12cce_ram #(
    .Width (12),
    .Depth (NUM_CLUSTERS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    res_d   = res_q;
    sidx_d  = sidx_q;
    own_d   = own_q;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        res_d = '0;
        unique case (req_q.func) inside
          fat12cce_pkg::FuncLoad: begin
            if (lower_ok) begin
              res_d.pair_offset = fat12cce_pkg::pair_offset(cl);
              we      = 1'b1;
              waddr   = cl[AddrW-1:0] & ~AddrW'(1);
              wdata   = req_q.packed_in[11:0];
              state_d = S_LOADHI;
            end else begin
              res_d.status = 1'b1;
              done_d       = 1'b1;
              state_d      = S_IDLE;
            end
          end
          fat12cce_pkg::FuncRead, fat12cce_pkg::FuncExtend, fat12cce_pkg::FuncClose: begin
            if (cl_ok) begin
              res_d.pair_offset = fat12cce_pkg::pair_offset(cl);
              raddr   = cl[AddrW-1:0];
              state_d = S_EVAL;
            end else begin
              res_d.status = 1'b1;
              done_d       = 1'b1;
              state_d      = S_IDLE;
            end
          end
          fat12cce_pkg::FuncFind: begin
            raddr   = '0;
            sidx_d  = '0;
            state_d = S_SCAN;
          end
          default: begin
            res_d.status = 1'b1;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end
        endcase
      end

      S_LOADHI: begin
        // With an odd table size the upper half of the last pair is dropped.
        if (hi_ok) begin
          we    = 1'b1;
          waddr = cl[AddrW-1:0] | AddrW'(1);
          wdata = req_q.packed_in[23:12];
        end
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      S_EVAL: begin
        unique case (req_q.func)
          fat12cce_pkg::FuncExtend: begin
            if (rdata == fat12cce_pkg::LinkFree || rdata >= fat12cce_pkg::LinkEocMin) begin
              // Mark the entry first so the scan cannot pick it as free.
              we      = 1'b1;
              waddr   = cl[AddrW-1:0];
              wdata   = fat12cce_pkg::LinkEoc;
              raddr   = '0;
              sidx_d  = '0;
              state_d = S_SCAN;
            end else begin
              res_d.next_cluster = rdata;
              done_d             = 1'b1;
              state_d            = S_IDLE;
            end
          end
          fat12cce_pkg::FuncClose: begin
            if (rdata == fat12cce_pkg::LinkFree) begin
              we      = 1'b1;
              waddr   = cl[AddrW-1:0];
              wdata   = fat12cce_pkg::LinkEoc;
              own_d   = fat12cce_pkg::LinkEoc;
              raddr   = partner_ok ? partner[AddrW-1:0] : '0;
              state_d = S_PACK;
            end else begin
              res_d.next_cluster = rdata;
              done_d             = 1'b1;
              state_d            = S_IDLE;
            end
          end
          default: begin
            res_d.next_cluster = rdata;
            done_d             = 1'b1;
            state_d            = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        // rdata holds the entry at sidx_q, read in the previous cycle.
        if (rdata == fat12cce_pkg::LinkFree || sidx_q == LastIdx) begin
          if (req_q.func == fat12cce_pkg::FuncExtend) begin
            we      = 1'b1;
            waddr   = cl[AddrW-1:0];
            wdata   = free_idx;
            own_d   = free_idx;
            raddr   = partner_ok ? partner[AddrW-1:0] : '0;
            state_d = S_PACK;
          end else begin
            res_d.next_cluster = free_idx;
            done_d             = 1'b1;
            state_d            = S_IDLE;
          end
        end else begin
          raddr  = sidx_q + AddrW'(1);
          sidx_d = sidx_q + AddrW'(1);
        end
      end

      S_PACK: begin
        res_d.next_cluster = own_q;
        res_d.write_back   = 1'b1;
        res_d.packed_out   = cl[0] ? fat12cce_pkg::pack_pair(partner_val, own_q)
                                   : fat12cce_pkg::pack_pair(own_q, partner_val);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    res_q  <= res_d;
    sidx_q <= sidx_d;
    own_q  <= own_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  `FAT12CCE_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy,
                        "accepted beat did not make the engine busy")
  `FAT12CCE_ASSERT_NOW(a_done_after_busy, done_o, $past(busy),
                       "result strobe without a beat in progress")
  `FAT12CCE_ASSERT_NOW(a_wb_only_ok, done_o && res_o.write_back, !res_o.status,
                       "write-back flagged on a rejected beat")
  `FAT12CCE_ASSERT_NOW(a_status_clears, done_o && res_o.status,
                       res_o.next_cluster == 12'd0 && res_o.packed_out == 24'd0
                       && res_o.pair_offset == 13'd0,
                       "rejected beat carries nonzero result fields")

endmodule

`default_nettype wire
